>>> rtl/core/nearest_palette_color_search_macros.svh
// assertion macros shared by the palette search modules
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define NPCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/npcs_pkg.sv
// types and constants of the nearest palette color search
`default_nettype none

package npcs_pkg;

    localparam int OP_W    = 1;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 24;
    localparam int CHAN_W  = 8;
    localparam int SQ_W    = 16;
    localparam int DIST_W  = 18;
    localparam int SIZE_W  = 9;
    localparam int INDEX_LIMIT = 256;

    localparam logic [OP_W-1:0] OP_WRITE    = 1'b0;
    localparam logic [OP_W-1:0] OP_CLASSIFY = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd1;
    localparam logic [DIST_W-1:0] DIST_MAX   = 18'd195075;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_DELIVER
    } t_state;

    typedef struct packed {
        logic clear;     // zero one store entry
        logic wr_entry;  // write the accepted entry word
        logic capture;   // hold the accepted pixel
        logic issue;     // read one entry for comparison
        logic first;     // issued entry is the first of the search
        logic last;      // issued entry is the last of the search
        logic load_out;  // move the winner into the output register
    } t_cmd;

    typedef struct packed {
        logic done;      // last comparison has updated the best
        logic out_busy;  // output register holds a word that is not taken
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/npcs_ram.sv
// generic single write port ram with registered read
`default_nettype none

module npcs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/npcs_ctrl.sv
// controller: clear pass, entry counter, search sequencing and delivery
`default_nettype none

module npcs_ctrl #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    input  wire logic [npcs_pkg::OP_W-1:0]             i_op,
    input  wire logic                                  i_cfg_we,
    input  wire logic [npcs_pkg::SIZE_W-1:0]           i_cfg_data,
    input  wire npcs_pkg::t_status                     i_status,
    output logic                                       o_stall,
    output npcs_pkg::t_cmd                             o_cmd,
    output logic [$clog2((PALETTE_DEPTH < npcs_pkg::INDEX_LIMIT) ?
                         PALETTE_DEPTH : npcs_pkg::INDEX_LIMIT)-1:0] o_cnt
);

    `include "nearest_palette_color_search_macros.svh"

    localparam int LIMIT = (PALETTE_DEPTH < npcs_pkg::INDEX_LIMIT) ?
                           PALETTE_DEPTH : npcs_pkg::INDEX_LIMIT;
    localparam int SW = $clog2(LIMIT);

    npcs_pkg::t_state            r_state, n_state;
    logic [SW-1:0]               r_cnt, n_cnt;
    logic [SW-1:0]               r_last, n_last;
    logic [npcs_pkg::SIZE_W-1:0] r_size, n_size;
    logic [npcs_pkg::SIZE_W-1:0] w_last_full;
    logic                        w_accept;
    logic                        w_at_end;

    assign w_accept = (r_state == npcs_pkg::ST_IDLE) && i_valid;
    assign w_at_end = (r_cnt == r_last);

    // zero and oversize sizes clamp to one and to the searchable limit
    always_comb begin
        if (r_size == '0) begin
            w_last_full = '0;
        end else if (r_size > npcs_pkg::SIZE_W'(LIMIT)) begin
            w_last_full = npcs_pkg::SIZE_W'(LIMIT - 1);
        end else begin
            w_last_full = r_size - 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            npcs_pkg::ST_CLEAR: begin
                if (r_cnt == SW'(LIMIT - 1)) begin
                    n_state = npcs_pkg::ST_IDLE;
                end
            end
            npcs_pkg::ST_IDLE: begin
                if (w_accept && (i_op == npcs_pkg::OP_CLASSIFY)) begin
                    n_state = npcs_pkg::ST_SEARCH;
                end
            end
            npcs_pkg::ST_SEARCH: begin
                if (w_at_end) begin
                    n_state = npcs_pkg::ST_DRAIN;
                end
            end
            npcs_pkg::ST_DRAIN: begin
                if (i_status.done) begin
                    n_state = npcs_pkg::ST_DELIVER;
                end
            end
            npcs_pkg::ST_DELIVER: begin
                if (!i_status.out_busy) begin
                    n_state = npcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            npcs_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            npcs_pkg::ST_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.wr_entry = w_accept && (i_op == npcs_pkg::OP_WRITE);
                o_cmd.capture  = w_accept && (i_op == npcs_pkg::OP_CLASSIFY);
            end
            npcs_pkg::ST_SEARCH: begin
                o_cmd.issue = 1'b1;
                o_cmd.first = (r_cnt == '0);
                o_cmd.last  = w_at_end;
            end
            npcs_pkg::ST_DRAIN: begin
                o_cmd = '0;
            end
            npcs_pkg::ST_DELIVER: begin
                o_cmd.load_out = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // counter, search length and size register
    always_comb begin
        n_cnt  = r_cnt;
        n_last = r_last;
        n_size = r_size;
        if (i_cfg_we) begin
            n_size = i_cfg_data;
        end
        if ((r_state == npcs_pkg::ST_CLEAR) || (r_state == npcs_pkg::ST_SEARCH)) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (o_cmd.capture) begin
            n_cnt  = '0;
            n_last = w_last_full[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcs_pkg::ST_CLEAR;
            r_cnt   <= '0;
            r_size  <= npcs_pkg::SIZE_RESET;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_size  <= n_size;
        end
        r_last <= n_last;
    end

    assign o_cnt = r_cnt;

    `NPCS_ASSERT_IMPL(a_cnt_in_range, i_clk, i_rst_n,
        r_state == npcs_pkg::ST_SEARCH, r_cnt <= r_last,
        "search counter ran past the last entry")
    `NPCS_ASSERT_NEXT(a_drain_to_deliver, i_clk, i_rst_n,
        (r_state == npcs_pkg::ST_DRAIN) && i_status.done, r_state == npcs_pkg::ST_DELIVER,
        "finished search did not move to delivery")
    `NPCS_ASSERT_IMPL(a_stall_when_busy, i_clk, i_rst_n,
        r_state != npcs_pkg::ST_IDLE, o_stall,
        "input taken while the search was busy")

endmodule

`default_nettype wire

>>> rtl/core/npcs_dp.sv
// datapath: palette store, distance pipeline, best tracking, output register
`default_nettype none

module npcs_dp #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire npcs_pkg::t_cmd                        i_cmd,
    input  wire logic [$clog2((PALETTE_DEPTH < npcs_pkg::INDEX_LIMIT) ?
                              PALETTE_DEPTH : npcs_pkg::INDEX_LIMIT)-1:0] i_cnt,
    input  wire logic [npcs_pkg::IDX_W-1:0]            i_entry_index,
    input  wire logic [npcs_pkg::COLOR_W-1:0]          i_color,
    input  wire logic                                  i_stall,
    output npcs_pkg::t_status                          o_status,
    output logic                                       o_valid,
    output logic [npcs_pkg::IDX_W-1:0]                 o_palette_index,
    output logic [npcs_pkg::DIST_W-1:0]                o_best_distance
);

    `include "nearest_palette_color_search_macros.svh"

    localparam int LIMIT = (PALETTE_DEPTH < npcs_pkg::INDEX_LIMIT) ?
                           PALETTE_DEPTH : npcs_pkg::INDEX_LIMIT;
    localparam int SW = $clog2(LIMIT);
    localparam int AW = $clog2(PALETTE_DEPTH);
    // one bit above the address so the depth itself fits in the compare
    localparam int XW = ((AW + 1) > npcs_pkg::IDX_W) ? (AW + 1) : npcs_pkg::IDX_W;
    localparam int NCH = npcs_pkg::COLOR_W / npcs_pkg::CHAN_W;

    function automatic logic [npcs_pkg::SQ_W-1:0] sq_diff(
        input logic [npcs_pkg::CHAN_W-1:0] a,
        input logic [npcs_pkg::CHAN_W-1:0] b
    );
        logic [npcs_pkg::CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return npcs_pkg::SQ_W'(d) * npcs_pkg::SQ_W'(d);
    endfunction

    logic [XW-1:0]                  w_idx_x;
    logic                           w_wr_ok;
    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    logic [npcs_pkg::COLOR_W-1:0]   w_wdata;
    logic [npcs_pkg::COLOR_W-1:0]   w_rdata;

    logic [npcs_pkg::COLOR_W-1:0]   r_pixel;
    logic                           r_v1, r_first1, r_last1;
    logic [SW-1:0]                  r_idx1;
    logic                           r_v2, r_first2, r_last2;
    logic [SW-1:0]                  r_idx2;
    logic [npcs_pkg::SQ_W-1:0]      r_sq [NCH];
    logic [npcs_pkg::SQ_W-1:0]      n_sq [NCH];
    logic [npcs_pkg::DIST_W-1:0]    w_sum;
    logic                           w_take;
    logic [npcs_pkg::DIST_W-1:0]    r_best;
    logic [SW-1:0]                  r_best_idx;
    logic                           r_done;
    logic                           r_out_valid;
    logic [npcs_pkg::IDX_W-1:0]     r_out_idx;
    logic [npcs_pkg::DIST_W-1:0]    r_out_dist;

    // writes past the store depth are dropped
    assign w_idx_x = XW'(i_entry_index);
    assign w_wr_ok = (w_idx_x < XW'(PALETTE_DEPTH));
    assign w_we    = i_cmd.clear || (i_cmd.wr_entry && w_wr_ok);
    assign w_waddr = i_cmd.clear ? AW'(i_cnt) : w_idx_x[AW-1:0];
    assign w_wdata = i_cmd.clear ? '0 : i_color;

    npcs_ram #(
        .WIDTH (npcs_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (AW'(i_cnt)),
        .o_rdata (w_rdata)
    );

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_sq[c] = sq_diff(r_pixel[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W],
                              w_rdata[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W]);
        end
    end

    assign w_sum = npcs_pkg::DIST_W'(r_sq[0]) + npcs_pkg::DIST_W'(r_sq[1])
                 + npcs_pkg::DIST_W'(r_sq[2]);

    // only a strictly smaller distance replaces the best, so ties keep the low index
    assign w_take = r_v2 && (r_first2 || (w_sum < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1   <= i_cmd.issue;
            r_v2   <= r_v1;
            r_done <= r_v2 && r_last2;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_pixel <= i_color;
        end
        r_first1 <= i_cmd.first;
        r_last1  <= i_cmd.last;
        r_idx1   <= i_cnt;
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_idx2   <= r_idx1;
        r_sq     <= n_sq;
        if (w_take) begin
            r_best     <= w_sum;
            r_best_idx <= r_idx2;
        end
        if (i_cmd.load_out) begin
            r_out_idx  <= npcs_pkg::IDX_W'(r_best_idx);
            r_out_dist <= r_best;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.out_busy = r_out_valid && i_stall;
    assign o_valid           = r_out_valid;
    assign o_palette_index   = r_out_idx;
    assign o_best_distance   = r_out_dist;

    `NPCS_ASSERT_IMPL(a_pipe_empty_at_done, i_clk, i_rst_n,
        r_done, !r_v1 && !r_v2,
        "entries still in flight when search reported done")
    `NPCS_ASSERT_IMPL(a_dist_bound, i_clk, i_rst_n,
        r_out_valid, r_out_dist <= npcs_pkg::DIST_MAX,
        "delivered distance above the rgb maximum")
    `NPCS_ASSERT_NEXT(a_out_held, i_clk, i_rst_n,
        r_out_valid && i_stall,
        r_out_valid && $stable(r_out_idx) && $stable(r_out_dist),
        "stalled result word changed")

endmodule

`default_nettype wire

>>> rtl/core/nearest_palette_color_search.sv
// top level of the nearest palette color search
//
//  channel   direction   handshake           payload
//  input     in          i_valid / o_stall   i_op, i_entry_index, i_color
//  result    out         o_valid / i_stall   o_palette_index, o_best_distance
//  config    in          i_cfg_we            i_cfg_data (search size)
//
// a write word goes straight into the store; a classify word searches n entries, n being the
// clamped palette size, through the single store read port, comparing the entries in turn
// after reset a clearing pass zeroes min(PALETTE_DEPTH, 256) entries in turn,
// with o_stall high; config writes are taken during it
// the result sits in an output register, so a new word is taken while it waits;
// a finished classify holds in delivery until that register is free
`default_nettype none

module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [npcs_pkg::OP_W-1:0]         i_op,
    input  wire logic [npcs_pkg::IDX_W-1:0]        i_entry_index,
    input  wire logic [npcs_pkg::COLOR_W-1:0]      i_color,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic [npcs_pkg::IDX_W-1:0]             o_palette_index,
    output logic [npcs_pkg::DIST_W-1:0]            o_best_distance,
    input  wire logic                              i_cfg_we,
    input  wire logic [npcs_pkg::SIZE_W-1:0]       i_cfg_data
);

    localparam int LIMIT = (PALETTE_DEPTH < npcs_pkg::INDEX_LIMIT) ?
                           PALETTE_DEPTH : npcs_pkg::INDEX_LIMIT;
    localparam int SW = $clog2(LIMIT);

    npcs_pkg::t_cmd    w_cmd;
    npcs_pkg::t_status w_status;
    logic [SW-1:0]     w_cnt;

    npcs_ctrl #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_status   (w_status),
        .o_stall    (o_stall),
        .o_cmd      (w_cmd),
        .o_cnt      (w_cnt)
    );

    npcs_dp #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cnt           (w_cnt),
        .i_entry_index   (i_entry_index),
        .i_color         (i_color),
        .i_stall         (i_stall),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .o_palette_index (o_palette_index),
        .o_best_distance (o_best_distance)
    );

endmodule

`default_nettype wire

>>> test/nearest_palette_color_search_tb.sv
// self-checking testbench for the nearest palette color search
`default_nettype none

module nearest_palette_color_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = 256;
    localparam int SEARCH_LIMIT  = (DEPTH < npcs_pkg::INDEX_LIMIT) ? DEPTH
                                                                   : npcs_pkg::INDEX_LIMIT;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int TAIL_CYCLES   = SEARCH_LIMIT + 40;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [npcs_pkg::IDX_W-1:0]  palette_index;
        logic [npcs_pkg::DIST_W-1:0] best_distance;
    } t_winner;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [npcs_pkg::OP_W-1:0]      i_op = npcs_pkg::OP_WRITE;
    logic [npcs_pkg::IDX_W-1:0]     i_entry_index = '0;
    logic [npcs_pkg::COLOR_W-1:0]   i_color = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [npcs_pkg::IDX_W-1:0]     o_palette_index;
    logic [npcs_pkg::DIST_W-1:0]    o_best_distance;
    logic                           i_cfg_we = 1'b0;
    logic [npcs_pkg::SIZE_W-1:0]    i_cfg_data = '0;

    // shadow of the block's palette and size register
    logic [npcs_pkg::COLOR_W-1:0]   palette_copy [DEPTH];
    logic [npcs_pkg::SIZE_W-1:0]    search_size;
    t_winner                        pending_winners [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    nearest_palette_color_search #(
        .PALETTE_DEPTH(DEPTH)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_op(i_op),
        .i_entry_index(i_entry_index),
        .i_color(i_color),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_palette_index(o_palette_index),
        .o_best_distance(o_best_distance),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_entries();
        int n;
        n = search_size;
        if (n == 0) n = 1;
        if (n > SEARCH_LIMIT) n = SEARCH_LIMIT;
        return n;
    endfunction

    function automatic logic [npcs_pkg::DIST_W-1:0] color_distance(
        logic [npcs_pkg::COLOR_W-1:0] a,
        logic [npcs_pkg::COLOR_W-1:0] b
    );
        int d;
        int sum;
        sum = 0;
        for (int c = 0; c < 3; c++) begin
            d = a[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W];
            d = d - b[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W];
            sum += d * d;
        end
        return npcs_pkg::DIST_W'(sum);
    endfunction

    // strictly smaller replaces, so the lowest index wins a tie
    function automatic t_winner find_nearest_entry(logic [npcs_pkg::COLOR_W-1:0] pixel);
        t_winner best;
        logic [npcs_pkg::DIST_W-1:0] d;
        best.palette_index = '0;
        best.best_distance = color_distance(pixel, palette_copy[0]);
        for (int i = 1; i < active_entries(); i++) begin
            d = color_distance(pixel, palette_copy[i]);
            if (d < best.best_distance) begin
                best.best_distance = d;
                best.palette_index = npcs_pkg::IDX_W'(i);
            end
        end
        return best;
    endfunction

    function automatic logic [npcs_pkg::CHAN_W-1:0] channel_edge();
        return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    endfunction

    function automatic logic [npcs_pkg::COLOR_W-1:0] nudge_color(
        logic [npcs_pkg::COLOR_W-1:0] base
    );
        logic [npcs_pkg::COLOR_W-1:0] moved;
        int v;
        for (int c = 0; c < 3; c++) begin
            v = base[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W];
            v = v + $urandom_range(12) - 6;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            moved[c*npcs_pkg::CHAN_W +: npcs_pkg::CHAN_W] = npcs_pkg::CHAN_W'(v);
        end
        return moved;
    endfunction

    function automatic void report_failure(string what, int want, int got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s expected %0d actual %0d", $realtime, what, want, got);
    endfunction

    task automatic send_word(logic [npcs_pkg::OP_W-1:0] op, logic [npcs_pkg::IDX_W-1:0] idx,
                             logic [npcs_pkg::COLOR_W-1:0] color);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_op = op;
        i_entry_index = idx;
        i_color = color;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (op == npcs_pkg::OP_WRITE) begin
            if (idx < DEPTH) palette_copy[idx] = color;
        end else begin
            pending_winners.insert(pending_winners.size(), find_nearest_entry(color));
        end
    endtask

    task automatic pause_until_drained(int settle);
        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_winners.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // the block must be idle, so the task first waits until every pending result is taken
    task automatic set_palette_size(logic [npcs_pkg::SIZE_W-1:0] value);
        pause_until_drained(SETTLE_CYCLES);
        i_cfg_we = 1'b1;
        i_cfg_data = value;
        search_size = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_winner want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_winners.size() == 0) begin
                report_failure("result word with nothing pending", -1, o_palette_index);
            end else begin
                want = pending_winners.pop_front();
                if (o_palette_index !== want.palette_index)
                    report_failure("palette_index", want.palette_index, o_palette_index);
                if (o_best_distance !== want.best_distance)
                    report_failure("best_distance", want.best_distance, o_best_distance);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // store is all zero and size is one right after reset
    task automatic test_reset_state();
        send_word(npcs_pkg::OP_CLASSIFY, 8'h00, 24'h000000);
        send_word(npcs_pkg::OP_CLASSIFY, 8'hFF, 24'hFFFFFF);
    endtask

    task automatic test_size_extremes();
        set_palette_size(9'd0);
        send_word(npcs_pkg::OP_WRITE, 8'd0, 24'hFFFFFF);
        send_word(npcs_pkg::OP_WRITE, 8'd1, 24'h000000);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h000000);
        set_palette_size(9'h1FF);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h000000);
        set_palette_size(9'd256);
        send_word(npcs_pkg::OP_WRITE, 8'd255, 24'h123456);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h123456);
    endtask

    task automatic test_tie_break();
        send_word(npcs_pkg::OP_WRITE, 8'd128, 24'h808080);
        send_word(npcs_pkg::OP_WRITE, 8'd200, 24'h808080);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h808080);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h7F8081);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h000001);
        set_palette_size(9'd2);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h808080);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h7F7F7F);
    endtask

    task automatic test_channel_extremes();
        set_palette_size(9'd5);
        send_word(npcs_pkg::OP_WRITE, 8'd2, 24'hFF0000);
        send_word(npcs_pkg::OP_WRITE, 8'd3, 24'h00FF00);
        send_word(npcs_pkg::OP_WRITE, 8'd4, 24'h0000FF);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'hF00000);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h00F000);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'h0000F0);
        send_word(npcs_pkg::OP_CLASSIFY, 8'd0, 24'hFF00FF);
    endtask

    // each phase loads up to twelve of the searched entries, then mixes pixels and rewrites
    task automatic test_random_traffic(int send_pct, int recv_pct);
        int n;
        int pick;
        int quota;
        logic [npcs_pkg::SIZE_W-1:0]  size_choice;
        logic [npcs_pkg::IDX_W-1:0]   idx;
        logic [npcs_pkg::COLOR_W-1:0] color;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: size_choice = npcs_pkg::SIZE_W'($urandom_range(1, 8));
                1: size_choice = npcs_pkg::SIZE_W'($urandom_range(9, 48));
                2: size_choice = 9'd0;
                3: size_choice = ($urandom_range(1) != 0) ? 9'd256
                               : npcs_pkg::SIZE_W'($urandom_range(257, 511));
                default: size_choice = npcs_pkg::SIZE_W'($urandom_range(2, 16));
            endcase
            set_palette_size(size_choice);
            n = active_entries();
            quota = (phase == 3) ? 20 : 74;
            for (int k = 0; k < quota; k++) begin
                if (phase == 1 && k == quota / 2) pause_until_drained(0);
                pick = $urandom_range(99);
                if (k < n && k < 12) begin
                    send_word(npcs_pkg::OP_WRITE, npcs_pkg::IDX_W'(k),
                              npcs_pkg::COLOR_W'($urandom()));
                end else if (pick < 25) begin
                    idx = ($urandom_range(9) < 7) ? npcs_pkg::IDX_W'($urandom_range(n - 1))
                                                 : npcs_pkg::IDX_W'($urandom_range(255));
                    pick = $urandom_range(99);
                    if (pick < 60)
                        color = npcs_pkg::COLOR_W'($urandom());
                    else if (pick < 80)
                        color = palette_copy[$urandom_range(n - 1)];
                    else
                        color = {channel_edge(), channel_edge(), channel_edge()};
                    send_word(npcs_pkg::OP_WRITE, idx, color);
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        color = nudge_color(palette_copy[$urandom_range(n - 1)]);
                    else if (pick < 80)
                        color = npcs_pkg::COLOR_W'($urandom());
                    else if (pick < 90)
                        color = palette_copy[$urandom_range(n - 1)];
                    else
                        color = {channel_edge(), channel_edge(), channel_edge()};
                    send_word(npcs_pkg::OP_CLASSIFY, npcs_pkg::IDX_W'($urandom_range(255)),
                              color);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) palette_copy[i] = '0;
        search_size = npcs_pkg::SIZE_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        send_idle_pct = 30;
        recv_idle_pct = 46;
        test_reset_state();
        test_size_extremes();
        test_tie_break();
        test_channel_extremes();
        test_random_traffic(30, 46);
        test_random_traffic(46, 30);
        test_random_traffic(0, 0);
        pause_until_drained(TAIL_CYCLES);
        mismatches += pending_winners.size();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/npcs_pkg.sv
rtl/core/npcs_ram.sv
rtl/core/npcs_ctrl.sv
rtl/core/npcs_dp.sv
rtl/core/nearest_palette_color_search.sv
test/nearest_palette_color_search_tb.sv
